// File: rtl/ring_sector_inside_test_core_assert.svh
// assertion macros for the ring sector test core
// no dependencies; included by the top level
`ifndef RING_SECTOR_INSIDE_TEST_CORE_ASSERT_SVH
`define RING_SECTOR_INSIDE_TEST_CORE_ASSERT_SVH

// same-cycle implication, reset masked
`define RSIT_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define RSIT_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rsit_pkg.sv
// shared types, constants and the angle table of the ring sector test
// no dependencies
package rsit_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);

    // result codes, two bit signed
    localparam logic [1:0] CODE_IN  = 2'b01;
    localparam logic [1:0] CODE_ON  = 2'b00;
    localparam logic [1:0] CODE_OUT = 2'b11;

    // register indexes
    localparam logic [2:0] REG_CENTER_RE   = 3'd0;
    localparam logic [2:0] REG_CENTER_IM   = 3'd1;
    localparam logic [2:0] REG_RING_RADIUS = 3'd2;
    localparam logic [2:0] REG_VERT_SCALE  = 3'd3;
    localparam logic [2:0] REG_START_FRAC  = 3'd4;
    localparam logic [2:0] REG_END_FRAC    = 3'd5;
    localparam logic [2:0] REG_RING_WIDTH  = 3'd6;

    typedef struct packed {
        logic signed [31:0] center_re;
        logic signed [31:0] center_im;
        logic [31:0]        ring_radius;
        logic [31:0]        vert_scale;
        logic [16:0]        start_frac;
        logic [16:0]        end_frac;
        logic [31:0]        ring_width;
    } cfg_t;

    // classified point handed from front to back
    typedef struct packed {
        logic [1:0]  code;
        logic [29:0] nx;
        logic [29:0] ny;
        logic        ux_zero;
        logic        uy_zero;
        logic        dx_neg;
        logic        dy_neg;
    } qitem_t;

    // one cordic stage
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic [1:0]         code;
        logic               ux_zero;
        logic               uy_zero;
        logic               dx_neg;
        logic               dy_neg;
    } cstage_t;

    // atan(2^-i) in Q0.32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/rsit_front.sv
// front pipeline: offsets, exact ellipse tests and vector normalization
// depends on rsit_pkg
module rsit_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  rsit_pkg::cfg_t     cfg,
    input  logic               q_full,
    output logic               q_push,
    output rsit_pkg::qitem_t   q_item
);
    import rsit_pkg::*;

    localparam int SW = 134;

    logic [4:0] v_reg;
    logic       en;

    // stage 1
    logic [32:0] adx_reg, ady_reg;
    logic [33:0] ao_reg;
    logic [32:0] ai_reg;
    logic        dxn_reg, dyn_reg;
    // stage 2
    logic [65:0] po_reg;
    logic [65:0] pi_reg;
    logic [63:0] ux_reg;
    logic [32:0] ady2_reg;
    logic        dxn2_reg, dyn2_reg;
    // stage 3
    logic [67:0] hh_reg [3];
    logic [65:0] hl_reg [3];
    logic [63:0] ll_reg [3];
    logic [65:0] ss_reg;
    logic [63:0] cx_reg, cy_reg;
    logic        uxz3_reg, uyz3_reg, dxn3_reg, dyn3_reg;
    // stage 4
    logic [SW-1:0] po4_reg, pi4_reg, qs4_reg;
    logic [29:0]   nx4_reg, ny4_reg;
    logic          uxz4_reg, uyz4_reg, dxn4_reg, dyn4_reg;
    // stage 5
    qitem_t item_reg;

    assign en       = !v_reg[4] || !q_full;
    assign in_ready = en;
    assign q_push   = v_reg[4] && !q_full;
    assign q_item   = item_reg;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // stage 1: offsets and doubled semi-axes
    logic signed [32:0] dx1, dy1;
    logic signed [33:0] ai_d;
    always_comb begin
        dx1  = 33'(point_x) - 33'(cfg.center_re);
        dy1  = 33'(point_y) - 33'(cfg.center_im);
        ai_d = $signed({1'b0, cfg.ring_radius, 1'b0}) - $signed({2'b0, cfg.ring_width});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adx_reg <= dx1[32] ? 33'(-dx1) : 33'(dx1);
            ady_reg <= dy1[32] ? 33'(-dy1) : 33'(dy1);
            dxn_reg <= dx1[32];
            dyn_reg <= dy1[32];
            ao_reg  <= {1'b0, cfg.ring_radius, 1'b0} + {2'b0, cfg.ring_width};
            ai_reg  <= ai_d[33] ? 33'(-ai_d) : 33'(ai_d);
        end
    end

    // stage 2: products with the vertical scale
    always_ff @(posedge aclk) begin
        if (en) begin
            po_reg   <= 66'(ao_reg) * 66'(cfg.vert_scale);
            pi_reg   <= 66'(ai_reg) * 66'(cfg.vert_scale);
            ux_reg   <= 64'(65'(adx_reg) * 65'(cfg.vert_scale));
            ady2_reg <= ady_reg;
            dxn2_reg <= dxn_reg;
            dyn2_reg <= dyn_reg;
        end
    end

    // stage 3: partial products of the squares, coarse byte normalization
    logic [65:0] sq_in [3];
    logic [63:0] uy2, m3;
    logic [2:0]  lzb;
    always_comb begin
        sq_in[0] = po_reg;
        sq_in[1] = pi_reg;
        sq_in[2] = {1'b0, ux_reg, 1'b0};
        uy2      = {15'b0, ady2_reg, 16'b0};
        m3       = ux_reg | uy2;
        lzb      = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (m3[8*i +: 8] != 8'd0) lzb = 3'(7 - i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                hh_reg[k] <= 68'(sq_in[k][65:32]) * 68'(sq_in[k][65:32]);
                hl_reg[k] <= 66'(sq_in[k][65:32]) * 66'(sq_in[k][31:0]);
                ll_reg[k] <= 64'(sq_in[k][31:0]) * 64'(sq_in[k][31:0]);
            end
            ss_reg   <= 66'(ady2_reg) * 66'(ady2_reg);
            cx_reg   <= ux_reg << {lzb, 3'b0};
            cy_reg   <= uy2 << {lzb, 3'b0};
            uxz3_reg <= (ux_reg == 64'd0);
            uyz3_reg <= (ady2_reg == 33'd0);
            dxn3_reg <= dxn2_reg;
            dyn3_reg <= dyn2_reg;
        end
    end

    // stage 4: square sums, fine bit normalization
    logic [SW-1:0] sq [3];
    logic [63:0]   m4, fx, fy;
    logic [2:0]    lzf;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sq[k] = (SW'(hh_reg[k]) << 64) + (SW'(hl_reg[k]) << 33) + SW'(ll_reg[k]);
        end
        m4  = cx_reg | cy_reg;
        lzf = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (m4[56 + b]) lzf = 3'(7 - b);
        end
        fx = cx_reg << lzf;
        fy = cy_reg << lzf;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            po4_reg  <= sq[0];
            pi4_reg  <= sq[1];
            qs4_reg  <= sq[2] + (SW'(ss_reg) << 34);
            nx4_reg  <= fx[63:34];
            ny4_reg  <= fy[63:34];
            uxz4_reg <= uxz3_reg;
            uyz4_reg <= uyz3_reg;
            dxn4_reg <= dxn3_reg;
            dyn4_reg <= dyn3_reg;
        end
    end

    // stage 5: sign product of outer and inner tests
    logic [1:0] co, ci, code5;
    always_comb begin
        co = (po4_reg > qs4_reg) ? CODE_IN : ((po4_reg == qs4_reg) ? CODE_ON : CODE_OUT);
        ci = (qs4_reg > pi4_reg) ? CODE_IN : ((qs4_reg == pi4_reg) ? CODE_ON : CODE_OUT);
        if (co == CODE_ON || ci == CODE_ON) begin
            code5 = CODE_ON;
        end else if (co == ci) begin
            code5 = CODE_IN;
        end else begin
            code5 = CODE_OUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg.code    <= code5;
            item_reg.nx      <= nx4_reg;
            item_reg.ny      <= ny4_reg;
            item_reg.ux_zero <= uxz4_reg;
            item_reg.uy_zero <= uyz4_reg;
            item_reg.dx_neg  <= dxn4_reg;
            item_reg.dy_neg  <= dyn4_reg;
        end
    end

endmodule

// File: rtl/rsit_queue.sv
// short register queue between front and back pipelines
// depends on rsit_pkg
module rsit_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rsit_pkg::qitem_t push_item,
    input  logic             pop,
    output rsit_pkg::qitem_t pop_item,
    output logic             full,
    output logic             not_empty,
    output logic [rsit_pkg::Q_AW:0] count
);
    import rsit_pkg::*;

    qitem_t        mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, rd_reg;
    logic [Q_AW:0]   cnt_reg;

    assign full      = (cnt_reg == (Q_AW+1)'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;
    assign pop_item  = mem_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_item;
    end

endmodule

// File: rtl/rsit_back.sv
// back pipeline: cordic stages, quadrant mapping and sector span check
// depends on rsit_pkg
module rsit_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_not_empty,
    input  rsit_pkg::qitem_t q_item,
    output logic             q_pop,
    input  rsit_pkg::cfg_t   cfg,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_code
);
    import rsit_pkg::*;

    localparam int FW = ANGLE_BITS + 17;
    localparam logic [ANGLE_BITS:0] F_ONE     = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
    localparam logic [ANGLE_BITS:0] F_HALF    = F_ONE >> 1;
    localparam logic [ANGLE_BITS:0] F_QUARTER = F_ONE >> 2;
    localparam logic [ANGLE_BITS:0] F_3QUART  = F_HALF + F_QUARTER;
    localparam logic [34:0] RND     = 35'(1) << (31 - ANGLE_BITS);
    localparam logic [34:0] QUARTER = 35'(1) << (ANGLE_BITS - 2);

    cstage_t st_reg [CORDIC_ITERS+1];
    logic [CORDIC_ITERS:0] v_reg;
    logic       out_v_reg;
    logic [1:0] out_code_reg;
    logic       en;

    assign en        = !out_v_reg || out_ready;
    assign q_pop     = en && q_not_empty;
    assign out_valid = out_v_reg;
    assign out_code  = out_code_reg;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v_reg     <= {v_reg[CORDIC_ITERS-1:0], q_pop};
            out_v_reg <= v_reg[CORDIC_ITERS];
        end
    end

    // load from queue
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].x       <= $signed({3'b0, q_item.nx});
            st_reg[0].y       <= $signed({3'b0, q_item.ny});
            st_reg[0].z       <= '0;
            st_reg[0].code    <= q_item.code;
            st_reg[0].ux_zero <= q_item.ux_zero;
            st_reg[0].uy_zero <= q_item.uy_zero;
            st_reg[0].dx_neg  <= q_item.dx_neg;
            st_reg[0].dy_neg  <= q_item.dy_neg;
        end
    end

    // one vectoring rotation per stage
    for (genvar k = 1; k <= CORDIC_ITERS; k++) begin : g_cordic
        cstage_t cur, nxt;
        logic signed [32:0] xs, ys;
        logic signed [33:0] at;
        always_comb begin
            cur = st_reg[k-1];
            nxt = cur;
            xs  = cur.x >>> (k - 1);
            ys  = cur.y >>> (k - 1);
            at  = $signed({2'b0, atan_turn(5'(k - 1))});
            if (!cur.y[32]) begin
                nxt.x = cur.x + ys;
                nxt.y = cur.y - xs;
                nxt.z = cur.z + at;
            end else begin
                nxt.x = cur.x - ys;
                nxt.y = cur.y + xs;
                nxt.z = cur.z - at;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) st_reg[k] <= nxt;
        end
    end

    // rounding, quadrant mapping and span check
    cstage_t            fin;
    logic [34:0]        zpos, qraw, qc;
    logic [ANGLE_BITS:0] q, f;
    logic [FW-1:0]      fs, ss, es;
    logic               undef;
    logic [1:0]         code_o;
    always_comb begin
        fin   = st_reg[CORDIC_ITERS];
        zpos  = fin.z[33] ? 35'd0 : 35'(fin.z);
        qraw  = (zpos + RND) >> (32 - ANGLE_BITS);
        qc    = (qraw > QUARTER) ? QUARTER : qraw;
        q     = qc[ANGLE_BITS:0];
        undef = fin.ux_zero && fin.uy_zero;
        if (fin.ux_zero) begin
            f = fin.dy_neg ? F_3QUART : F_QUARTER;
        end else if (!fin.dy_neg) begin
            f = fin.dx_neg ? F_HALF - q : q;
        end else begin
            f = fin.dx_neg ? F_HALF + q : F_ONE - q;
        end
        fs = FW'(f) << 16;
        ss = FW'(cfg.start_frac) << ANGLE_BITS;
        es = FW'(cfg.end_frac) << ANGLE_BITS;
        code_o = fin.code;
        if (fin.code == CODE_IN) begin
            if (ss > es) begin
                if (!undef && fs > es && fs < ss) code_o = CODE_OUT;
            end else begin
                if (undef || fs < ss || fs > es) code_o = CODE_OUT;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) out_code_reg <= code_o;
    end

endmodule

// File: rtl/ring_sector_inside_test_core.sv
// top level of the elliptical ring sector test: registers, front, queue, back
// depends on rsit_pkg, rsit_front, rsit_queue, rsit_back and the assertion header
//
// Takes one point per clock while s_tready is high and returns one code per
// point, in order: +1 inside the ring sector, 0 on either ellipse, -1 outside.
// Sustained rate is one transfer per cycle on each side while neither stalls.
// The input transfer loads the first of 5 front stages; after the fifth the
// point enters the 4-entry queue, then passes a load stage, CORDIC_ITERS
// rotation stages and one output stage. The front stalls only when the queue
// is full, the back only when the output register is held, so either side can
// pause without starving the other. Registers are to be written through cfg_*
// only while no point is in flight; the block itself does not enforce this.
`include "ring_sector_inside_test_core_assert.svh"

module ring_sector_inside_test_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // point_x [31:0], point_y [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // inside_code [1:0], zero [7:2]
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import rsit_pkg::*;

    cfg_t   cfg_reg;
    qitem_t push_item, pop_item;
    logic   q_push, q_pop, q_full, q_not_empty;
    logic [Q_AW:0] q_count;
    logic [1:0] code;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_re   <= '0;
            cfg_reg.center_im   <= '0;
            cfg_reg.ring_radius <= 32'hFFFF_FFFF;
            cfg_reg.vert_scale  <= 32'd65536;
            cfg_reg.start_frac  <= 17'd0;
            cfg_reg.end_frac    <= 17'd65536;
            cfg_reg.ring_width  <= 32'd6554;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER_RE:   cfg_reg.center_re   <= cfg_wdata;
                REG_CENTER_IM:   cfg_reg.center_im   <= cfg_wdata;
                REG_RING_RADIUS: cfg_reg.ring_radius <= cfg_wdata;
                REG_VERT_SCALE:  cfg_reg.vert_scale  <= cfg_wdata;
                REG_START_FRAC:  cfg_reg.start_frac  <= cfg_wdata[16:0];
                REG_END_FRAC:    cfg_reg.end_frac    <= cfg_wdata[16:0];
                REG_RING_WIDTH:  cfg_reg.ring_width  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // classify
    rsit_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .point_x  (s_tdata[31:0]),
        .point_y  (s_tdata[63:32]),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // decouple
    rsit_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    // angle and span
    rsit_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .cfg         (cfg_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_code    (code)
    );

    assign m_tdata = {6'b0, code};

    // checks
    `RSIT_ASSERT_IMP(a_code_legal, aclk, aresetn, m_tvalid, code != 2'b10, "illegal result code")
    `RSIT_ASSERT_IMP(a_stall_full, aclk, aresetn, !s_tready, q_full, "front stalled with queue room")
    `RSIT_ASSERT_NXT(a_q_count, aclk, aresetn, q_push && !q_pop,
        q_count == $past(q_count) + 1'b1, "queue count lost a transfer")

endmodule
